### sv/hrip_pkg.sv
package hrip_pkg;

  // Width of the collection depth field, and the largest depth it can hold.
  localparam int DEPTH_W         = 4;
  localparam int DEPTH_MAX       = (2 ** DEPTH_W) - 1;
  localparam int MAX_NESTING_DEF = 15;

  // Prefix byte that opens a long item.
  localparam logic [7:0] LONG_PREFIX = 8'hfe;

  // Item types.
  localparam logic [1:0] TYPE_MAIN     = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL   = 2'd1;
  localparam logic [1:0] TYPE_RESERVED = 2'd3;

  // Tags with a side effect on the tracked state.
  localparam logic [3:0] TAG_COLLECTION     = 4'ha;
  localparam logic [3:0] TAG_END_COLLECTION = 4'hc;
  localparam logic [3:0] TAG_USAGE_PAGE     = 4'h0;
  localparam logic [3:0] TAG_LONG           = 4'hf;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_DATA,
    PH_LSIZE,
    PH_LSKIP
  } hrip_phase_t;

  // One descriptor byte on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_descriptor;
  } hrip_in_word_t;

  // One parsed item on the result channel.
  typedef struct packed {
    logic [1:0]         item_type;
    logic [3:0]         item_tag;
    logic [2:0]         data_size;
    logic [31:0]        value_unsigned;
    logic signed [31:0] value_signed;
    logic [DEPTH_W-1:0] nesting_depth;
    logic [15:0]        usage_page;
    logic               is_long_item;
    logic [7:0]         long_data_size;
    logic               truncated;
  } hrip_out_word_t;

  // Result from the parser core towards the output register.
  typedef struct packed {
    logic           valid;
    hrip_out_word_t word;
  } hrip_res_t;

  // Data byte count of a short item; size code 3 means four bytes.
  function automatic logic [2:0] short_size(input logic [7:0] prefix);
    logic [2:0] s;
    s = {1'b0, prefix[1:0]};
    if (s == 3'd3) begin
      s = 3'd4;
    end
    return s;
  endfunction

  // Signed value of a short item: sign-extended for one and two bytes.
  function automatic logic [31:0] sext_value(input logic [2:0] size, input logic [31:0] vu);
    logic [31:0] vs;
    vs = vu;
    case (size)
      3'd0: vs = 32'h0;
      3'd1: if (vu[7]) vs = vu | 32'hffffff00;
      3'd2: if (vu[15]) vs = vu | 32'hffff0000;
      default: vs = vu;
    endcase
    return vs;
  endfunction

endpackage

### sv/hrip_in_stage.sv
module hrip_in_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hrip_pkg::hrip_in_word_t in_word,
  input  logic                   advance,
  output logic                   s1_valid,
  output hrip_pkg::hrip_in_word_t s1_word
);
  import hrip_pkg::*;

  logic           valid_r;
  hrip_in_word_t  word_r;

  // A new word may enter when the register is empty or drains this cycle.
  assign in_ready = !valid_r || advance;
  assign s1_valid = valid_r;
  assign s1_word  = word_r;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

### sv/hrip_core.sv
module hrip_core #(
  parameter int MAX_NESTING = hrip_pkg::MAX_NESTING_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  hrip_pkg::hrip_in_word_t s1_word,
  output hrip_pkg::hrip_res_t     res
);
  import hrip_pkg::*;

  localparam int DepthCap = (MAX_NESTING > DEPTH_MAX) ? DEPTH_MAX : MAX_NESTING;
  localparam logic [DEPTH_W-1:0] CapVal = DEPTH_W'(DepthCap);

  // Parser state.
  hrip_phase_t        phase_r,  phase_nxt,  phase_adv;
  logic [7:0]         prefix_r, prefix_nxt, prefix_adv;
  logic [2:0]         left_r,   left_nxt,   left_adv;
  logic [1:0]         pos_r,    pos_nxt,    pos_adv;
  logic [31:0]        acc_r,    acc_nxt,    acc_adv;
  logic [8:0]         skip_r,   skip_nxt,   skip_adv;
  logic [7:0]         lsize_r,  lsize_nxt,  lsize_adv;
  logic [DEPTH_W-1:0] depth_r,  depth_nxt,  depth_adv;
  logic [15:0]        page_r,   page_nxt,   page_adv;

  logic [7:0]         b;
  logic               eod;
  logic [7:0]         pre_sel;
  logic [31:0]        acc_merged;
  logic [2:0]         left_dec;
  logic [8:0]         skip_dec;
  logic               finish;
  logic [31:0]        fin_acc;
  logic [1:0]         fin_type;
  logic [3:0]         fin_tag;
  logic [2:0]         fin_size;
  logic               is_coll;
  logic               is_end;
  logic               is_page;
  logic [DEPTH_W-1:0] depth_inc;
  logic [DEPTH_W-1:0] depth_dec;

  assign b   = s1_word.data_byte;
  assign eod = s1_word.end_of_descriptor;

  // Shared decode of the byte against the current phase.
  assign pre_sel    = (phase_r == PH_PREFIX) ? b : prefix_r;
  assign acc_merged = acc_r | ({24'h0, b} << {pos_r, 3'b000});
  assign left_dec   = (left_r != 3'd0) ? left_r - 3'd1 : 3'd0;
  assign skip_dec   = (skip_r != 9'd0) ? skip_r - 9'd1 : 9'd0;
  assign finish     = ((phase_r == PH_PREFIX) && (b != LONG_PREFIX) &&
                       (short_size(b) == 3'd0)) ||
                      ((phase_r == PH_DATA) && (left_dec == 3'd0));
  assign fin_acc    = (phase_r == PH_PREFIX) ? 32'h0 : acc_merged;
  assign fin_type   = pre_sel[3:2];
  assign fin_tag    = pre_sel[7:4];
  assign fin_size   = short_size(pre_sel);
  assign is_coll    = finish && (fin_type == TYPE_MAIN) && (fin_tag == TAG_COLLECTION);
  assign is_end     = finish && (fin_type == TYPE_MAIN) && (fin_tag == TAG_END_COLLECTION);
  assign is_page    = finish && (fin_type == TYPE_GLOBAL) && (fin_tag == TAG_USAGE_PAGE);
  assign depth_inc  = (depth_r < CapVal) ? depth_r + 1'b1 : depth_r;
  assign depth_dec  = (depth_r != '0) ? depth_r - 1'b1 : depth_r;

  // State after the byte, before the end of the descriptor is applied.
  always_comb begin
    phase_adv  = phase_r;
    prefix_adv = prefix_r;
    left_adv   = left_r;
    pos_adv    = pos_r;
    acc_adv    = acc_r;
    skip_adv   = skip_r;
    lsize_adv  = lsize_r;
    depth_adv  = depth_r;
    page_adv   = page_r;
    case (phase_r)
      PH_PREFIX: begin
        prefix_adv = b;
        if (b == LONG_PREFIX) begin
          phase_adv = PH_LSIZE;
        end else begin
          acc_adv  = 32'h0;
          pos_adv  = 2'd0;
          left_adv = short_size(b);
          if (short_size(b) != 3'd0) begin
            phase_adv = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        acc_adv  = acc_merged;
        pos_adv  = pos_r + 2'd1;
        left_adv = left_dec;
        if (left_dec == 3'd0) begin
          phase_adv = PH_PREFIX;
        end
      end
      PH_LSIZE: begin
        lsize_adv = b;
        skip_adv  = {1'b0, b} + 9'd1;
        phase_adv = PH_LSKIP;
      end
      PH_LSKIP: begin
        skip_adv = skip_dec;
        if (skip_dec == 9'd0) begin
          phase_adv = PH_PREFIX;
        end
      end
      default: begin
        phase_adv = PH_PREFIX;
      end
    endcase
    if (is_coll) begin
      depth_adv = depth_inc;
    end
    if (is_end) begin
      depth_adv = depth_dec;
    end
    if (is_page) begin
      page_adv = fin_acc[15:0];
    end
  end

  // Next state: the final byte of a descriptor returns everything to reset.
  always_comb begin
    phase_nxt  = phase_adv;
    prefix_nxt = prefix_adv;
    left_nxt   = left_adv;
    pos_nxt    = pos_adv;
    acc_nxt    = acc_adv;
    skip_nxt   = skip_adv;
    lsize_nxt  = lsize_adv;
    depth_nxt  = depth_adv;
    page_nxt   = page_adv;
    if (eod) begin
      phase_nxt  = PH_PREFIX;
      prefix_nxt = 8'h0;
      left_nxt   = 3'd0;
      pos_nxt    = 2'd0;
      acc_nxt    = 32'h0;
      skip_nxt   = 9'd0;
      lsize_nxt  = 8'h0;
      depth_nxt  = '0;
      page_nxt   = 16'h0;
    end
  end

  // Result of this byte: a complete item, a long item header or a truncation.
  always_comb begin
    res = '0;
    res.word.nesting_depth = depth_r;
    res.word.usage_page    = page_r;
    if (finish) begin
      res.valid                = 1'b1;
      res.word.item_type       = fin_type;
      res.word.item_tag        = fin_tag;
      res.word.data_size       = fin_size;
      res.word.value_unsigned  = fin_acc;
      res.word.value_signed    = sext_value(fin_size, fin_acc);
      res.word.nesting_depth   = is_end ? depth_dec : depth_r;
      res.word.usage_page      = is_page ? fin_acc[15:0] : page_r;
    end else if (phase_r == PH_LSIZE) begin
      res.valid                = 1'b1;
      res.word.item_type       = TYPE_RESERVED;
      res.word.item_tag        = TAG_LONG;
      res.word.is_long_item    = 1'b1;
      res.word.long_data_size  = b;
      res.word.truncated       = eod;
    end else if (eod && (phase_adv != PH_PREFIX)) begin
      res.valid                = 1'b1;
      res.word.truncated       = 1'b1;
      if (phase_adv == PH_DATA) begin
        res.word.item_type      = prefix_adv[3:2];
        res.word.item_tag       = prefix_adv[7:4];
        res.word.data_size      = short_size(prefix_adv);
        res.word.value_unsigned = acc_adv;
        res.word.value_signed   = acc_adv;
      end else begin
        res.word.item_type      = TYPE_RESERVED;
        res.word.item_tag       = TAG_LONG;
        res.word.is_long_item   = 1'b1;
        res.word.long_data_size = (phase_adv == PH_LSKIP) ? lsize_r : 8'h0;
      end
    end
  end

  // State registers, updated once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      prefix_r <= 8'h0;
      left_r   <= 3'd0;
      pos_r    <= 2'd0;
      acc_r    <= 32'h0;
      skip_r   <= 9'd0;
      lsize_r  <= 8'h0;
      depth_r  <= '0;
      page_r   <= 16'h0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      prefix_r <= prefix_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      skip_r   <= skip_nxt;
      lsize_r  <= lsize_nxt;
      depth_r  <= depth_nxt;
      page_r   <= page_nxt;
    end
  end

`ifndef SYNTH
  // Depth never passes the configured ceiling.
  a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CapVal)
    else $error("collection depth above ceiling");

  // While skipping a long item at least one byte is still owed.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LSKIP) |-> (skip_r != 9'd0))
    else $error("long skip phase with nothing left to skip");

  // Bytes gathered plus bytes owed always equal the declared item size.
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |->
      ((left_r != 3'd0) && ((left_r + {1'b0, pos_r}) == short_size(prefix_r))))
    else $error("data byte count out of step with prefix");

  // The final byte of a descriptor leaves the parser in its reset state.
  a_eod_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (step && eod) |=> ((phase_r == PH_PREFIX) && (depth_r == '0) && (page_r == 16'h0)))
    else $error("state not cleared after end of descriptor");
`endif

endmodule

### sv/hrip_out_stage.sv
module hrip_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  hrip_pkg::hrip_res_t      res,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hrip_pkg::hrip_out_word_t out_word
);
  import hrip_pkg::*;

  logic           valid_r;
  hrip_out_word_t word_r;
  logic           load;

  assign load      = advance && res.valid;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res.word;
    end
  end

endmodule

### sv/hid_report_item_parser_top.sv
// Channel  | Ports                              | Word
// ---------+------------------------------------+-----------------------------
// input    | in_valid, in_ready, in_word        | one descriptor byte
// result   | out_valid, out_ready, out_word     | one parsed item
//
// The core takes one byte per cycle while the result register is not stalled;
// a byte waits in the input register and its result in the result register.
// The rate is set by the single core stage between input and result registers.
// Reset is synchronous on rst_n low and returns the parser to the prefix phase.
// A stalled result register holds the core; the input register takes a byte
// only while empty, and that byte waits until the result is taken.
module hid_report_item_parser_top #(
  parameter int MAX_NESTING = hrip_pkg::MAX_NESTING_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hrip_pkg::hrip_in_word_t  in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hrip_pkg::hrip_out_word_t out_word
);
  import hrip_pkg::*;

  logic          s1_valid;
  hrip_in_word_t s1_word;
  logic          advance;
  hrip_res_t     res;

  // The held byte moves on when the result register is free or being drained.
  assign advance = s1_valid && (!out_valid || out_ready);

  hrip_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  hrip_core #(
    .MAX_NESTING (MAX_NESTING)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .s1_word (s1_word),
    .res     (res)
  );

  hrip_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
